// ===== hw/rtl/bomix_pkg.sv =====
// Shared types, constants and the coefficient table of the obstacle mixer.
`timescale 1ns / 1ps

package bomix_pkg;

  localparam int SENSOR_COUNT = 8;

  // Register indexes taken from cfg_paddr[3:2].
  localparam logic [1:0] REG_LED_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_CROWD_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WHEEL_BIAS      = 2'd2;

  localparam logic [11:0]       LED_THRESHOLD_RESET   = 12'd300;
  localparam logic [14:0]       CROWD_THRESHOLD_RESET = 15'd2400;
  localparam logic signed [10:0] WHEEL_BIAS_RESET     = 11'sd200;

  // Division by 300 as a multiply by ceil(2^30 / 300); exact for magnitudes below 2^22.
  localparam logic [21:0] SCALE_RECIP = 22'd3579140;
  localparam int          SCALE_SHIFT = 30;

  // Attenuation divides by 8192.
  localparam int          ATTEN_SHIFT = 13;

  localparam logic [2:0] LAST_SENSOR = 3'(SENSOR_COUNT - 1);

  typedef struct packed {
    logic signed [10:0] drive_right;
    logic signed [10:0] drive_left;
    logic [11:0]        proximity;
  } in_item_t;

  // Running frame totals after one sample has been folded in.
  typedef struct packed {
    logic [2:0]          sensor_number;
    logic                led_on;
    logic                frame_done;
    logic signed [21:0]  acc_left;
    logic signed [21:0]  acc_right;
    logic [14:0]         sample_sum;
    logic [11:0]         sample_max;
    logic signed [10:0]  drive_left;
    logic signed [10:0]  drive_right;
  } frame_t;

  // Products ready for the final wheel sum.
  typedef struct packed {
    logic [2:0]          sensor_number;
    logic                led_on;
    logic                frame_done;
    logic signed [10:0]  drive_left;
    logic signed [10:0]  drive_right;
    logic signed [23:0]  atten_left;
    logic signed [23:0]  atten_right;
    logic [13:0]         quot_left;
    logic                quot_left_neg;
    logic [13:0]         quot_right;
    logic                quot_right_neg;
  } mix_t;

  typedef struct packed {
    logic [2:0]          sensor_number;
    logic                led_on;
    logic                frame_done;
    logic signed [12:0]  wheel_left;
    logic signed [12:0]  wheel_right;
  } result_t;

  // Entries 0..7 weigh the right sum, entries 8..15 the left sum.
  function automatic logic signed [7:0] coef(input logic [3:0] i);
    logic signed [7:0] c;
    case (i)
      4'd0:    c = 8'sd18;
      4'd1:    c = 8'sd28;
      4'd2:    c = 8'sd36;
      4'd3:    c = 8'sd10;
      4'd4:    c = 8'sd8;
      4'd5:    c = -8'sd36;
      4'd6:    c = -8'sd58;
      4'd7:    c = -8'sd72;
      4'd8:    c = -8'sd72;
      4'd9:    c = -8'sd58;
      4'd10:   c = -8'sd36;
      4'd11:   c = 8'sd8;
      4'd12:   c = 8'sd10;
      4'd13:   c = 8'sd36;
      4'd14:   c = 8'sd28;
      4'd15:   c = 8'sd18;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/bomix_accum.sv =====
// Frame accumulation stage: sensor counter, weighted sums, sample sum and maximum.
`timescale 1ns / 1ps

module bomix_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bomix_pkg::in_item_t item,
  input  logic [11:0]       led_threshold,
  output bomix_pkg::frame_t frame_r
);
  import bomix_pkg::*;

  logic [2:0]         counter_r, counter_nxt;
  logic signed [21:0] acc_left_r, acc_left_nxt;
  logic signed [21:0] acc_right_r, acc_right_nxt;
  logic [14:0]        sum_r, sum_nxt;
  logic [11:0]        max_r, max_nxt;

  logic signed [7:0]  coef_left, coef_right;
  logic signed [20:0] prod_left, prod_right;
  frame_t             frame_nxt;
  logic               done;

  assign done       = (counter_r == LAST_SENSOR);
  assign coef_right = coef({1'b0, counter_r});
  assign coef_left  = coef({1'b1, counter_r});
  assign prod_right = 21'(coef_right) * 21'($signed({1'b0, item.proximity}));
  assign prod_left  = 21'(coef_left) * 21'($signed({1'b0, item.proximity}));

  always_comb begin
    frame_nxt.sensor_number = counter_r;
    frame_nxt.led_on        = (item.proximity > led_threshold);
    frame_nxt.frame_done    = done;
    frame_nxt.acc_left      = acc_left_r + 22'(prod_left);
    frame_nxt.acc_right     = acc_right_r + 22'(prod_right);
    frame_nxt.sample_sum    = sum_r + 15'(item.proximity);
    frame_nxt.sample_max    = (item.proximity > max_r) ? item.proximity : max_r;
    frame_nxt.drive_left    = item.drive_left;
    frame_nxt.drive_right   = item.drive_right;

    // The frame state starts over once the eighth sample has been folded in.
    if (done) begin
      counter_nxt   = '0;
      acc_left_nxt  = '0;
      acc_right_nxt = '0;
      sum_nxt       = '0;
      max_nxt       = '0;
    end else begin
      counter_nxt   = counter_r + 3'd1;
      acc_left_nxt  = frame_nxt.acc_left;
      acc_right_nxt = frame_nxt.acc_right;
      sum_nxt       = frame_nxt.sample_sum;
      max_nxt       = frame_nxt.sample_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r   <= '0;
      acc_left_r  <= '0;
      acc_right_r <= '0;
      sum_r       <= '0;
      max_r       <= '0;
    end else if (en) begin
      counter_r   <= counter_nxt;
      acc_left_r  <= acc_left_nxt;
      acc_right_r <= acc_right_nxt;
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_r <= frame_nxt;
    end
  end

endmodule

// ===== hw/rtl/bomix_wheel.sv =====
// Wheel command stages: scaling, crowd attenuation and the final sum.
`timescale 1ns / 1ps

module bomix_wheel (
  input  logic               clk,
  input  logic               en_mix,
  input  logic               en_out,
  input  bomix_pkg::frame_t  frame,
  input  logic [14:0]        crowd_threshold,
  input  logic signed [10:0] wheel_bias,
  output bomix_pkg::result_t result_r
);
  import bomix_pkg::*;

  mix_t    mix_r, mix_nxt;
  result_t result_nxt;

  logic        crowded;
  logic [21:0] mag_left, mag_right;
  logic [43:0] qp_left, qp_right;

  logic signed [23:0] att_left, att_right;
  logic signed [15:0] q_left, q_right;
  logic signed [15:0] sum_left, sum_right;

  assign crowded   = (frame.sample_sum > crowd_threshold);
  assign mag_left  = frame.acc_left[21] ? 22'(-frame.acc_left) : frame.acc_left;
  assign mag_right = frame.acc_right[21] ? 22'(-frame.acc_right) : frame.acc_right;
  assign qp_left   = 44'(mag_left) * 44'(SCALE_RECIP);
  assign qp_right  = 44'(mag_right) * 44'(SCALE_RECIP);

  always_comb begin
    mix_nxt.sensor_number  = frame.sensor_number;
    mix_nxt.led_on         = frame.led_on;
    mix_nxt.frame_done     = frame.frame_done;
    mix_nxt.drive_left     = frame.drive_left;
    mix_nxt.drive_right    = frame.drive_right;
    mix_nxt.quot_left      = qp_left[SCALE_SHIFT +: 14];
    mix_nxt.quot_left_neg  = frame.acc_left[21];
    mix_nxt.quot_right     = qp_right[SCALE_SHIFT +: 14];
    mix_nxt.quot_right_neg = frame.acc_right[21];
    if (crowded) begin
      mix_nxt.atten_left  = 24'(frame.drive_left) * 24'($signed({1'b0, frame.sample_max}));
      mix_nxt.atten_right = 24'(frame.drive_right) * 24'($signed({1'b0, frame.sample_max}));
    end else begin
      mix_nxt.atten_left  = '0;
      mix_nxt.atten_right = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_mix) begin
      mix_r <= mix_nxt;
    end
  end

  // Negative products are biased before the shift so the quotient truncates toward zero.
  assign att_left  = (mix_r.atten_left + (mix_r.atten_left[23] ? 24'sd8191 : 24'sd0))
                     >>> ATTEN_SHIFT;
  assign att_right = (mix_r.atten_right + (mix_r.atten_right[23] ? 24'sd8191 : 24'sd0))
                     >>> ATTEN_SHIFT;
  assign q_left    = mix_r.quot_left_neg ? -$signed({2'b00, mix_r.quot_left})
                                         : $signed({2'b00, mix_r.quot_left});
  assign q_right   = mix_r.quot_right_neg ? -$signed({2'b00, mix_r.quot_right})
                                          : $signed({2'b00, mix_r.quot_right});
  assign sum_left  = 16'(mix_r.drive_left) - 16'(att_left) + q_left + 16'(wheel_bias);
  assign sum_right = 16'(mix_r.drive_right) - 16'(att_right) + q_right + 16'(wheel_bias);

  always_comb begin
    result_nxt.sensor_number = mix_r.sensor_number;
    result_nxt.led_on        = mix_r.led_on;
    result_nxt.frame_done    = mix_r.frame_done;
    result_nxt.wheel_left    = mix_r.frame_done ? sum_left[12:0] : '0;
    result_nxt.wheel_right   = mix_r.frame_done ? sum_right[12:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      result_r <= result_nxt;
    end
  end

endmodule

// ===== hw/rtl/braitenberg_obstacle_mix_unit.sv =====
// Top level of the obstacle mixer: register port, stream channels and pipeline control.
//
// Usage: the input stream carries one proximity sample per transaction, in sensor
// order zero to seven, together with the two base drive speeds. Each sample yields
// exactly one result transaction with its sensor number and obstacle flag; the result
// of the eighth sample carries tlast and the left and right wheel commands, the other
// results carry zero wheel fields.
// The pipeline has four register stages (input, accumulate, multiply, output), so one
// transaction per cycle is sustained while the receiver does not stall; the frame
// accumulators are updated in order in the accumulate stage.
// Reset clears the sensor counter, all frame totals, the stage valid bits and loads
// the register defaults; the first sample after reset is sensor zero.
// When the receiver stalls, the result holds in the output register and the earlier
// stages fill up; in_tready falls only once all four stages hold a transaction.
// Registers (APB, byte addresses): 0x0 led_threshold, 0x4 crowd_threshold,
// 0x8 wheel_bias. Write them only while the pipeline is empty.
`timescale 1ns / 1ps

module braitenberg_obstacle_mix_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] proximity, [22:12] drive_left, [33:23] drive_right, [39:34] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] sensor_number, [3] led_on, [16:4] wheel_left, [29:17] wheel_right, [31:30] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bomix_pkg::*;

  logic [11:0]        led_threshold_r;
  logic [14:0]        crowd_threshold_r;
  logic signed [10:0] wheel_bias_r;
  logic               cfg_write;

  logic valid_in_r, valid_in_nxt;
  logic valid_acc_r, valid_acc_nxt;
  logic valid_mix_r, valid_mix_nxt;
  logic valid_out_r, valid_out_nxt;
  logic adv_in, adv_acc, adv_mix, adv_out;

  in_item_t in_r;
  frame_t   frame;
  result_t  result;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_threshold_r   <= LED_THRESHOLD_RESET;
      crowd_threshold_r <= CROWD_THRESHOLD_RESET;
      wheel_bias_r      <= WHEEL_BIAS_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        REG_LED_THRESHOLD:   led_threshold_r   <= cfg_pwdata[11:0];
        REG_CROWD_THRESHOLD: crowd_threshold_r <= cfg_pwdata[14:0];
        REG_WHEEL_BIAS:      wheel_bias_r      <= $signed(cfg_pwdata[10:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LED_THRESHOLD:   cfg_prdata = 32'(led_threshold_r);
      REG_CROWD_THRESHOLD: cfg_prdata = 32'(crowd_threshold_r);
      REG_WHEEL_BIAS:      cfg_prdata = 32'(wheel_bias_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // A stage moves on when it is empty or the stage after it moves on.
  assign adv_out   = !valid_out_r || out_tready;
  assign adv_mix   = !valid_mix_r || adv_out;
  assign adv_acc   = !valid_acc_r || adv_mix;
  assign adv_in    = !valid_in_r || adv_acc;
  assign in_tready = adv_in;

  always_comb begin
    valid_in_nxt  = adv_in  ? in_tvalid   : valid_in_r;
    valid_acc_nxt = adv_acc ? valid_in_r  : valid_acc_r;
    valid_mix_nxt = adv_mix ? valid_acc_r : valid_mix_r;
    valid_out_nxt = adv_out ? valid_mix_r : valid_out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_in_r  <= 1'b0;
      valid_acc_r <= 1'b0;
      valid_mix_r <= 1'b0;
      valid_out_r <= 1'b0;
    end else begin
      valid_in_r  <= valid_in_nxt;
      valid_acc_r <= valid_acc_nxt;
      valid_mix_r <= valid_mix_nxt;
      valid_out_r <= valid_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= in_tdata[33:0];
    end
  end

  bomix_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (valid_in_r && adv_acc),
    .item          (in_r),
    .led_threshold (led_threshold_r),
    .frame_r       (frame)
  );

  bomix_wheel u_wheel (
    .clk             (clk),
    .en_mix          (adv_mix),
    .en_out          (adv_out),
    .frame           (frame),
    .crowd_threshold (crowd_threshold_r),
    .wheel_bias      (wheel_bias_r),
    .result_r        (result)
  );

  assign out_tvalid = valid_out_r;
  assign out_tlast  = result.frame_done;
  assign out_tdata  = {2'b00, result.wheel_right, result.wheel_left,
                       result.led_on, result.sensor_number};

endmodule

// ===== hw/rtl/bomix_checker.sv =====
// Port-level assertions for the obstacle mixer and their binding to the top level.
`timescale 1ns / 1ps

module bomix_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // The frame end marker goes with the last sensor and only with it.
  a_last_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[2:0] == 3'd7)))
    else $error("frame end does not match sensor seven");

  // Wheel commands are zero except at the end of a frame.
  a_wheel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[29:4] == 26'd0))
    else $error("wheel fields nonzero inside a frame");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind braitenberg_obstacle_mix_unit bomix_checker u_bomix_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
